// ===== rtl/was_pkg.sv =====
// ----------------------------------------------------------------------------
// was_pkg
// Shared types and constants of the windowed ARQ sender.
// ----------------------------------------------------------------------------
package was_pkg;

   localparam logic [1:0] OP_LOAD = 2'd0;
   localparam logic [1:0] OP_ACK  = 2'd1;
   localparam logic [1:0] OP_TICK = 2'd2;
   localparam logic [1:0] OP_SEND = 2'd3;

   localparam logic [1:0] REG_TIMEOUT = 2'd0;
   localparam logic [1:0] REG_WINDOW  = 2'd1;
   localparam logic [1:0] REG_PAYLOAD = 2'd2;

   localparam int REQ_BITS = 56;
   localparam int RSP_BITS = 72;

   // Largest payload per packet; larger register values are clamped to it.
   localparam int MAX_PAYLOAD = 8192;

   typedef struct packed {
      logic        send_valid;
      logic [15:0] send_id;
      logic [19:0] send_offset;
      logic [13:0] send_length;
      logic [15:0] header_total;
      logic        load_accepted;
      logic        ack_accepted;
      logic        ready_pulse;
      logic        busy_res;
   } result_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic start;      // capture the item and begin
      logic div_step;   // one restoring-division step
      logic scan_step;  // visit one window slot
      logic finish;     // commit and form the result
   } cmd_type;

   typedef struct packed {
      logic div_last;
      logic scan_last;
   } status_type;

endpackage

// ===== rtl/was_ctrl.sv =====
// ----------------------------------------------------------------------------
// was_ctrl
// Sequencer: accept, divide (load) or scan the window (other items), finish, then hold the result.
// ----------------------------------------------------------------------------
module was_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  logic [1:0]          opcode,
   output was_pkg::cmd_type    cmd,
   input  was_pkg::status_type status
);
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_DIV  = 3'd1;
   localparam logic [2:0] ST_SCAN = 3'd2;
   localparam logic [2:0] ST_FIN  = 3'd3;

   logic [2:0] state_ff, state_in;
   logic       out_ff, out_in;

   // A new item may enter while the previous result waits, as long as the
   // output register is free by the time it finishes.
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = out_ff;

   always_comb begin
      state_in      = state_ff;
      out_in        = out_ff && !rsp_tready;
      cmd           = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.start = 1'b1;
               if (opcode == was_pkg::OP_LOAD) state_in = ST_DIV;
               else state_in = ST_SCAN;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) state_in = ST_FIN;
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_last) state_in = ST_FIN;
         end
         ST_FIN: begin
            if (!out_ff || rsp_tready) begin
               cmd.finish = 1'b1;
               out_in     = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         out_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         out_ff   <= out_in;
      end
   end
endmodule

// ===== rtl/was_dp.sv =====
// ----------------------------------------------------------------------------
// was_dp
// Datapath: configuration registers, transfer state, window table, divider.
// ----------------------------------------------------------------------------
module was_dp #(
   parameter int WINDOW_SLOTS      = 16,
   parameter int MAX_MESSAGE_BYTES = 1048576
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [1:0]           csr_index,
   input  logic [15:0]          csr_wdata,
   input  logic [1:0]           opcode,
   input  logic [20:0]          message_length,
   input  logic [31:0]          ack_word,
   input  logic                 ack_complete,
   input  was_pkg::cmd_type     cmd,
   output was_pkg::status_type  status,
   output was_pkg::result_type  result
);
   localparam int SW = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
   localparam int CW = $clog2(WINDOW_SLOTS + 1);
   localparam logic [13:0] MAX_PAY = 14'(was_pkg::MAX_PAYLOAD);

   logic [15:0] timeout_ff;
   logic [4:0]  window_ff;
   logic [13:0] payload_ff;

   logic        busy_ff;
   logic [15:0] total_ff;
   logic [13:0] tail_ff;
   logic [15:0] next_ff;
   logic [16:0] head_ff;
   logic [CW-1:0] count_ff;
   logic [WINDOW_SLOTS-1:0] used_ff;
   logic [15:0] sid_ff [WINDOW_SLOTS];
   logic [15:0] age_ff [WINDOW_SLOTS];

   logic [1:0]  op_ff;
   logic [20:0] len_ff;
   logic [20:0] len_hold;
   logic [15:0] aid_ff;
   logic        aok_ff;
   logic [SW:0] idx_ff;
   logic        best_ok_ff, free_ok_ff, hit_ok_ff;
   logic [SW-1:0] best_ff, free_ff, hit_ff;
   // Restoring divider: quotient and remainder of len / payload.
   logic [20:0] quo_ff;
   logic [14:0] rem_ff;
   logic [4:0]  dcnt_ff;

   logic [13:0] pay;
   logic [4:0]  win;
   logic [SW-1:0] idx;
   logic [14:0] rsh;
   logic [15:0] sid_i;

   function automatic logic quo_len_ok(input logic [20:0] c);
      quo_len_ok = (c <= 21'd65535);
   endfunction

   assign pay = (payload_ff == 14'd0) ? 14'd1 : (payload_ff > MAX_PAY ? MAX_PAY : payload_ff);
   assign win = (window_ff == 5'd0) ? 5'd1 :
                ((32'(window_ff) > WINDOW_SLOTS) ? 5'(WINDOW_SLOTS) : window_ff);
   assign idx = idx_ff[SW-1:0];
   assign rsh = {rem_ff[13:0], len_ff[20]};
   assign sid_i = sid_ff[idx];
   assign status.div_last  = (dcnt_ff == 5'd20);
   assign status.scan_last = (idx_ff == (SW+1)'(WINDOW_SLOTS - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= 16'd100;
         window_ff  <= 5'd8;
         payload_ff <= 14'd1024;
      end else if (csr_we) begin
         unique case (csr_index)
            was_pkg::REG_TIMEOUT: timeout_ff <= csr_wdata;
            was_pkg::REG_WINDOW:  window_ff  <= csr_wdata[4:0];
            was_pkg::REG_PAYLOAD: payload_ff <= csr_wdata[13:0];
            default: ;
         endcase
      end
   end

   // Per-item work registers.
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         op_ff      <= opcode;
         len_ff     <= message_length;
         aid_ff     <= ack_word[15:0];
         aok_ff     <= ack_complete && ack_word[7:0] == ack_word[23:16]
                       && ack_word[15:8] == ack_word[31:24];
         idx_ff     <= '0;
         best_ok_ff <= 1'b0;
         free_ok_ff <= 1'b0;
         hit_ok_ff  <= 1'b0;
         best_ff    <= '0;
         free_ff    <= '0;
         hit_ff     <= '0;
         quo_ff     <= '0;
         rem_ff     <= '0;
         dcnt_ff    <= '0;
      end
      if (cmd.div_step) begin
         // Shift the dividend through len_ff; quotient collects in quo_ff.
         len_ff  <= {len_ff[19:0], 1'b0};
         dcnt_ff <= dcnt_ff + 5'd1;
         if (rsh >= {1'b0, pay}) begin
            rem_ff <= rsh - {1'b0, pay};
            quo_ff <= {quo_ff[19:0], 1'b1};
         end else begin
            rem_ff <= rsh;
            quo_ff <= {quo_ff[19:0], 1'b0};
         end
      end
      if (cmd.scan_step) begin
         idx_ff <= idx_ff + 1'b1;
         if (used_ff[idx] && sid_i == aid_ff && !hit_ok_ff) begin
            hit_ok_ff <= 1'b1;
            hit_ff    <= idx;
         end
         if (used_ff[idx] && age_ff[idx] >= timeout_ff &&
             (!best_ok_ff || sid_i < sid_ff[best_ff])) begin
            best_ok_ff <= 1'b1;
            best_ff    <= idx;
         end
         if (!used_ff[idx] && !free_ok_ff) begin
            free_ok_ff <= 1'b1;
            free_ff    <= idx;
         end
         // Ticks age in the scan, one slot a cycle.
         if (op_ff == was_pkg::OP_TICK && used_ff[idx] && age_ff[idx] != 16'hFFFF)
            age_ff[idx] <= age_ff[idx] + 16'd1;
      end
      if (cmd.finish && op_ff == was_pkg::OP_SEND && busy_ff && 32'(count_ff) < 32'(win)) begin
         if (best_ok_ff) age_ff[best_ff] <= '0;
         else if (next_ff < total_ff && free_ok_ff) begin
            sid_ff[free_ff] <= next_ff;
            age_ff[free_ff] <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) len_hold <= message_length;
   end

   // Commit and form the result.
   logic [15:0] snd_id;
   logic        snd_ok;
   logic [29:0] prod;
   logic [16:0] head_nx;
   logic [20:0] cnt;
   logic        len_in_range;
   logic        load_ok;
   logic        head_hit;
   logic        ack_done;
   was_pkg::result_type res_in;

   assign snd_id = best_ok_ff ? sid_ff[best_ff] : next_ff;
   assign snd_ok = busy_ff && 32'(count_ff) < 32'(win) &&
                   (best_ok_ff || (next_ff < total_ff && free_ok_ff));
   assign prod = snd_id * pay;
   assign head_nx = head_ff + 17'd1;
   // The quotient is rounded up when a remainder is left.
   assign cnt = quo_ff + ((rem_ff != 15'd0) ? 21'd1 : 21'd0);
   assign len_in_range = (32'(len_hold) <= MAX_MESSAGE_BYTES);
   assign load_ok = !busy_ff && quo_len_ok(cnt) && len_in_range;
   assign head_hit = aok_ff && ({1'b0, aid_ff} == head_ff);
   assign ack_done = head_hit && total_ff != 16'd0 && head_nx == {1'b0, total_ff};

   always_comb begin
      res_in = '0;
      res_in.busy_res = busy_ff;
      unique case (op_ff)
         was_pkg::OP_LOAD: begin
            res_in.load_accepted = load_ok;
            res_in.ready_pulse   = load_ok && cnt == 21'd0;
            res_in.busy_res      = busy_ff || (load_ok && cnt != 21'd0);
         end
         was_pkg::OP_ACK: begin
            res_in.ack_accepted = aok_ff && hit_ok_ff;
            res_in.ready_pulse  = ack_done;
            if (ack_done) res_in.busy_res = 1'b0;
         end
         was_pkg::OP_SEND: begin
            if (snd_ok) begin
               res_in.send_valid   = 1'b1;
               res_in.send_id      = snd_id;
               res_in.send_offset  = prod[19:0];
               res_in.send_length  = (17'(snd_id) + 17'd1 == 17'(total_ff)) ? tail_ff : pay;
               res_in.header_total = total_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) result <= res_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         total_ff <= '0;
         tail_ff  <= '0;
         next_ff  <= '0;
         head_ff  <= '0;
         count_ff <= '0;
         used_ff  <= '0;
      end else if (cmd.finish) begin
         unique case (op_ff)
            was_pkg::OP_LOAD: begin
               if (load_ok) begin
                  used_ff  <= '0;
                  count_ff <= '0;
                  next_ff  <= '0;
                  head_ff  <= '0;
                  if (cnt == 21'd0) begin
                     total_ff <= '0;
                     tail_ff  <= '0;
                  end else begin
                     total_ff <= cnt[15:0];
                     tail_ff  <= (rem_ff == 15'd0) ? pay : rem_ff[13:0];
                     busy_ff  <= 1'b1;
                  end
               end
            end
            was_pkg::OP_ACK: begin
               if (aok_ff && hit_ok_ff) begin
                  used_ff[hit_ff] <= 1'b0;
                  if (count_ff != '0) count_ff <= count_ff - 1'b1;
               end
               if (head_hit) head_ff <= head_nx;
               if (ack_done) begin
                  total_ff <= '0;
                  busy_ff  <= 1'b0;
               end
            end
            was_pkg::OP_SEND: begin
               if (snd_ok && !best_ok_ff) begin
                  used_ff[free_ff] <= 1'b1;
                  count_ff <= count_ff + 1'b1;
                  next_ff  <= next_ff + 16'd1;
               end
            end
            default: ;
         endcase
      end
   end
endmodule

// ===== rtl/windowed_arq_sender.sv =====
// ----------------------------------------------------------------------------
// windowed_arq_sender
// Control part of a windowed selective-repeat ARQ sender.
// ----------------------------------------------------------------------------
// Usage: items arrive on the req_ stream (load, ack, tick, send slot) and each
// gives exactly one result transfer on the rsp_ stream. Configuration is
// written through csr_we/csr_index/csr_wdata while the block is idle; the user
// must keep to this, as the block itself does not enforce it. A load runs a
// 21-step restoring divider for the packet count before its result is
// registered. Ack, tick and send-slot items instead scan the window table,
// one slot a cycle, before their result is registered.
// One item is in work at a time; the next one is taken once the result is
// registered. Reset clears the transfer state and valid bits and restores
// the register defaults (timeout 100, window 8, payload 1024). When the
// receiver stalls, the result is held; the next item waits in its final step.
// ----------------------------------------------------------------------------
module windowed_arq_sender #(
   parameter int WINDOW_SLOTS      = 16,
   parameter int MAX_MESSAGE_BYTES = 1048576
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // opcode[1:0], message_length[22:2], ack_word[54:23], ack_complete[55]
   input  logic [55:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // send_valid[0], send_id[16:1], send_offset[36:17], send_length[50:37],
   // header_total[66:51], load_accepted[67], ack_accepted[68],
   // ready_pulse[69], busy_res[70], zero[71]
   output logic [71:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   was_pkg::cmd_type    cmd;
   was_pkg::status_type status;
   was_pkg::result_type res;

   was_ctrl u_ctrl (
      .clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid, .rsp_tready,
      .opcode(req_tdata[1:0]), .cmd, .status
   );

   was_dp #(.WINDOW_SLOTS(WINDOW_SLOTS), .MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)) u_dp (
      .clock, .reset, .csr_we, .csr_index, .csr_wdata,
      .opcode(req_tdata[1:0]), .message_length(req_tdata[22:2]),
      .ack_word(req_tdata[54:23]), .ack_complete(req_tdata[55]),
      .cmd, .status, .result(res)
   );

   assign rsp_tdata = {1'b0, res.busy_res, res.ready_pulse, res.ack_accepted,
                       res.load_accepted, res.header_total, res.send_length,
                       res.send_offset, res.send_id, res.send_valid};
endmodule

// ===== rtl/was_checker.sv =====
// ----------------------------------------------------------------------------
// was_checker
// Port-level checks of the windowed ARQ sender.
// ----------------------------------------------------------------------------
module was_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [71:0] rsp_tdata
);
   // A result that is not taken stays put.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // An accepted item is never followed by another acceptance in the very next cycle.
   a_lat: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("item accepted back to back");

   // A sent packet always names a nonzero header total.
   a_tot: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> rsp_tdata[66:51] != 16'd0)
      else $error("packet without total");

   // Ready pulse leaves the block idle.
   a_rdy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[69] |-> !rsp_tdata[70])
      else $error("ready pulse while busy");
endmodule

bind windowed_arq_sender was_checker u_chk (
   .clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid, .rsp_tready, .rsp_tdata
);

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the windowed ARQ sender. Load, ack, tick and send
// items drive the request stream; a local model of the sender state predicts
// the one result of each accepted item, and every response transfer is
// checked against it field by field. Whole transfers with random content run
// under three idling patterns, with register changes between items.
// ----------------------------------------------------------------------------
module tb;

   localparam int  SLOTS     = 16;
   localparam int  MAX_MSG   = 1048576;
   localparam int  MAX_PAY   = 8192;
   localparam longint CYCLE_LIMIT = 3000000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [55:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = was_pkg::REG_TIMEOUT;
   logic [15:0] csr_wdata = '0;

   windowed_arq_sender u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Sender-side copy of the block's state and registers.
   int  cfg_timeout, cfg_window, cfg_payload;
   bit  busy;
   int  total, tail, next_id, head, used_count;
   bit  slot_used[SLOTS];
   int  slot_id[SLOTS];
   int  slot_age[SLOTS];

   was_pkg::result_type expected_results[$];
   int  tx_idle_pct = 0;
   int  rx_idle_pct = 0;
   int  items_sent = 0;
   int  mismatches = 0;
   longint cycles = 0;

   always @(negedge clock) rsp_tready <= ($urandom_range(99) >= rx_idle_pct);

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("windowed_arq_sender test failed");
         $finish;
      end
   end

   function automatic int eff_payload();
      if (cfg_payload == 0) return 1;
      if (cfg_payload > MAX_PAY) return MAX_PAY;
      return cfg_payload;
   endfunction

   function automatic int eff_window();
      if (cfg_window == 0) return 1;
      if (cfg_window > SLOTS) return SLOTS;
      return cfg_window;
   endfunction

   function automatic void clear_window();
      for (int i = 0; i < SLOTS; i++) slot_used[i] = 1'b0;
      used_count = 0;
   endfunction

   function automatic was_pkg::result_type arq_predict(logic [1:0] op, int len,
                                                       logic [31:0] word, bit complete);
      was_pkg::result_type r;
      longint p, cnt;
      int best, id, fr;
      r = '0;
      p = eff_payload();
      case (op)
         was_pkg::OP_LOAD: begin
            cnt = (len + p - 1) / p;
            if (!busy && len <= MAX_MSG && cnt <= 65535) begin
               clear_window();
               next_id = 0;
               head = 0;
               r.load_accepted = 1'b1;
               if (cnt == 0) begin
                  total = 0;
                  tail = 0;
                  r.ready_pulse = 1'b1;
               end else begin
                  total = int'(cnt);
                  tail = (len % p == 0) ? int'(p) : int'(len % p);
                  busy = 1'b1;
               end
            end
         end
         was_pkg::OP_ACK: begin
            if (complete && word[7:0] == word[23:16] && word[15:8] == word[31:24]) begin
               id = word[15:0];
               for (int i = 0; i < SLOTS; i++) begin
                  if (slot_used[i] && slot_id[i] == id) begin
                     slot_used[i] = 1'b0;
                     if (used_count > 0) used_count--;
                     r.ack_accepted = 1'b1;
                     break;
                  end
               end
               if (id == head) begin
                  head = (head + 1) & 17'h1FFFF;
                  if (total > 0 && head == total) begin
                     total = 0;
                     busy = 1'b0;
                     r.ready_pulse = 1'b1;
                  end
               end
            end
         end
         was_pkg::OP_TICK: begin
            for (int i = 0; i < SLOTS; i++)
               if (slot_used[i] && slot_age[i] < 65535) slot_age[i]++;
         end
         default: begin
            best = -1;
            id = -1;
            if (busy && used_count < eff_window()) begin
               for (int i = 0; i < SLOTS; i++)
                  if (slot_used[i] && slot_age[i] >= cfg_timeout &&
                      (best < 0 || slot_id[i] < slot_id[best]))
                     best = i;
               if (best >= 0) begin
                  id = slot_id[best];
                  slot_age[best] = 0;
               end else if (next_id < total) begin
                  fr = -1;
                  for (int i = 0; i < SLOTS; i++)
                     if (!slot_used[i]) begin
                        fr = i;
                        break;
                     end
                  if (fr >= 0) begin
                     id = next_id;
                     slot_used[fr] = 1'b1;
                     slot_id[fr] = id;
                     slot_age[fr] = 0;
                     used_count++;
                     next_id = (next_id + 1) & 16'hFFFF;
                  end
               end
            end
            if (id >= 0) begin
               r.send_valid   = 1'b1;
               r.send_id      = id[15:0];
               r.send_offset  = 20'((longint'(id) * p) & 20'hFFFFF);
               r.send_length  = 14'((id + 1 == total) ? tail : int'(p));
               r.header_total = total[15:0];
            end
         end
      endcase
      r.busy_res = busy;
      return r;
   endfunction

   always @(posedge clock) begin
      was_pkg::result_type e;
      logic [71:0] d;
      if (rsp_tvalid && rsp_tready) begin
         d = rsp_tdata;
         if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result transfer %h", d);
         end else begin
            e = expected_results.pop_front();
            if (d[0] !== e.send_valid || d[16:1] !== e.send_id ||
                d[36:17] !== e.send_offset || d[50:37] !== e.send_length ||
                d[66:51] !== e.header_total || d[67] !== e.load_accepted ||
                d[68] !== e.ack_accepted || d[69] !== e.ready_pulse ||
                d[70] !== e.busy_res) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("result mismatch: expected v=%0d id=%0d off=%0d len=%0d %s",
                           e.send_valid, e.send_id, e.send_offset, e.send_length, "");
                  $display("   tot=%0d la=%0d aa=%0d rp=%0d busy=%0d",
                           e.header_total, e.load_accepted, e.ack_accepted,
                           e.ready_pulse, e.busy_res);
                  $display("   got v=%0d id=%0d off=%0d len=%0d",
                           d[0], d[16:1], d[36:17], d[50:37]);
                  $display("   tot=%0d la=%0d aa=%0d rp=%0d busy=%0d",
                           d[66:51], d[67], d[68], d[69], d[70]);
               end
            end
         end
      end
   end

   task automatic send_item(logic [1:0] op, int len = 0, logic [31:0] word = 0,
                            bit complete = 1'b1);
      @(negedge clock);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {complete, word, len[20:0], op};
      do @(posedge clock); while (!req_tready);
      expected_results.push_back(arq_predict(op, len, word, complete));
      items_sent++;
   endtask

   task automatic send_ack(int id);
      send_item(was_pkg::OP_ACK, 0, {id[15:0], id[15:0]}, 1'b1);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, int value);
      wait_drained();
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[15:0];
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         was_pkg::REG_TIMEOUT: cfg_timeout = value & 16'hFFFF;
         was_pkg::REG_WINDOW:  cfg_window  = value & 5'h1F;
         was_pkg::REG_PAYLOAD: cfg_payload = value & 14'h3FFF;
         default: ;
      endcase
   endtask

   task automatic pick_pending(output int id, output bit found);
      int ids[$];
      for (int i = 0; i < SLOTS; i++) if (slot_used[i]) ids.push_back(slot_id[i]);
      found = ids.size() != 0;
      id = found ? ids[$urandom_range(ids.size() - 1)] : head;
   endtask

   // One well-formed transfer with random content, ended by acking the head.
   task automatic run_transfer(int max_items);
      int npk, len, id, r, steps;
      bit found;
      npk = $urandom_range(1, 24);
      len = (npk - 1) * eff_payload() + $urandom_range(1, eff_payload());
      if ($urandom_range(3) == 0) len = npk * eff_payload();
      if (len > MAX_MSG) len = MAX_MSG;
      send_item(was_pkg::OP_LOAD, len);
      steps = 0;
      while (busy && steps < max_items) begin
         r = $urandom_range(99);
         if (r < 35) begin
            pick_pending(id, found);
            if ($urandom_range(4) == 0) id = head;
            send_ack(id);
         end else if (r < 65) send_item(was_pkg::OP_SEND);
         else if (r < 88) send_item(was_pkg::OP_TICK);
         else if (r < 92) send_item(was_pkg::OP_LOAD, $urandom_range(MAX_MSG + 5));
         else if (r < 96) send_item(was_pkg::OP_ACK, 0, $urandom, $urandom_range(1));
         else begin
            pick_pending(id, found);
            send_item(was_pkg::OP_ACK, 0, {id[15:0] ^ 16'h0100, id[15:0]}, 1'b1);
         end
         steps++;
      end
      while (busy) send_ack(head);
   endtask

   task automatic test_directed();
      send_item(was_pkg::OP_SEND);
      send_item(was_pkg::OP_TICK);
      send_ack(0);
      send_ack(16'hFFFF);
      send_item(was_pkg::OP_ACK, 0, 32'h0000_0000, 1'b0);
      send_item(was_pkg::OP_ACK, 0, 32'h1234_1235, 1'b1);
      send_item(was_pkg::OP_LOAD, 0);
      send_item(was_pkg::OP_LOAD, MAX_MSG + 1);
      send_item(was_pkg::OP_LOAD, 21'h1FFFFF);
      write_reg(was_pkg::REG_PAYLOAD, 1);
      send_item(was_pkg::OP_LOAD, 65536);
      write_reg(was_pkg::REG_PAYLOAD, 1024);
      write_reg(was_pkg::REG_TIMEOUT, 1);
      write_reg(was_pkg::REG_WINDOW, 2);
      send_item(was_pkg::OP_LOAD, 3072);
      send_item(was_pkg::OP_LOAD, 10);
      send_item(was_pkg::OP_SEND);
      send_item(was_pkg::OP_SEND);
      send_item(was_pkg::OP_SEND);
      send_item(was_pkg::OP_TICK);
      send_ack(1);
      send_item(was_pkg::OP_SEND);
      send_item(was_pkg::OP_TICK);
      send_item(was_pkg::OP_SEND);
      send_ack(0);
      send_ack(0);
      while (busy) send_ack(head);
      write_reg(was_pkg::REG_PAYLOAD, 8192);
      send_item(was_pkg::OP_LOAD, MAX_MSG);
      send_item(was_pkg::OP_SEND);
      send_ack(0);
      send_ack(1);
   endtask

   // Register extremes, including a payload change in the middle of a transfer.
   task automatic test_register_extremes();
      write_reg(was_pkg::REG_WINDOW, 0);
      write_reg(was_pkg::REG_PAYLOAD, 0);
      write_reg(was_pkg::REG_TIMEOUT, 65535);
      run_transfer(30);
      write_reg(was_pkg::REG_WINDOW, 31);
      write_reg(was_pkg::REG_PAYLOAD, 16383);
      write_reg(was_pkg::REG_TIMEOUT, 1);
      send_item(was_pkg::OP_LOAD, 300000);
      repeat (3) send_item(was_pkg::OP_SEND);
      write_reg(was_pkg::REG_PAYLOAD, 700);
      repeat (3) send_item(was_pkg::OP_SEND);
      while (busy) send_ack(head);
      write_reg(was_pkg::REG_WINDOW, 16);
      write_reg(was_pkg::REG_PAYLOAD, 8193);
      run_transfer(40);
      write_reg(2'd3, 16'hFFFF);
   endtask

   task automatic test_random_transfers(int tx_pct, int rx_pct, int quota);
      int stop;
      tx_idle_pct = tx_pct;
      rx_idle_pct = rx_pct;
      stop = items_sent + quota;
      while (items_sent < stop) begin
         if ($urandom_range(2) == 0) write_reg(was_pkg::REG_TIMEOUT, $urandom_range(1, 6));
         if ($urandom_range(2) == 0) write_reg(was_pkg::REG_WINDOW, $urandom_range(1, 16));
         if ($urandom_range(2) == 0) write_reg(was_pkg::REG_PAYLOAD, $urandom_range(1, 2048));
         if ($urandom_range(9) == 0) write_reg(was_pkg::REG_TIMEOUT, $urandom_range(1, 65535));
         run_transfer($urandom_range(20, 80));
      end
   endtask

   initial begin
      cfg_timeout = 100;
      cfg_window  = 8;
      cfg_payload = 1024;
      busy = 1'b0;
      total = 0; tail = 0; next_id = 0; head = 0;
      clear_window();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_register_extremes();
      test_random_transfers(7, 80, 100);
      test_random_transfers(80, 7, 100);
      test_random_transfers(0, 0, 100);
      wait_drained();
      if (mismatches == 0 && expected_results.size() == 0) begin
         $display("windowed_arq_sender test passed");
      end else begin
         $display("windowed_arq_sender test failed");
      end
      $finish;
   end

endmodule
